FILE: rtl/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

    localparam int FUNC_W   = 4;
    localparam int SENSOR_W = 16;
    localparam int LEAF_W   = 4;
    localparam int VALVE_W  = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [LEAF_W-1:0] {
        LEAF_IDLE       = 4'd0,
        LEAF_ABORT      = 4'd1,
        LEAF_PAUSE_IDLE = 4'd2,
        LEAF_PAUSE_VENT = 4'd3,
        LEAF_N2_IDLE    = 4'd4,
        LEAF_N2_FILL    = 4'd5,
        LEAF_PRE_IDLE   = 4'd6,
        LEAF_PRE_VENT   = 4'd7,
        LEAF_PRE_FILL   = 4'd8,
        LEAF_OX_IDLE    = 4'd9,
        LEAF_OX_FILL    = 4'd10,
        LEAF_OX_VENT    = 4'd11,
        LEAF_POST_IDLE  = 4'd12,
        LEAF_POST_VENT  = 4'd13,
        LEAF_POST_FILL  = 4'd14
    } t_leaf;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_NONE      = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_STOP      = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_ABORT     = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE     = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_FILL_N2   = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_PRE_PRESS = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_FILL_OX   = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_POST_PRESS = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_READY     = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_RESUME    = 4'd9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_N2_TARGET     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LIMITS  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LIMITS    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_LIMITS   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OX_WEIGHT     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OX_VENT_TRIG  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OX_VENT_TGT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OX_VENT_TEMP  = 4'd7;

    // valve bit positions
    localparam int VALVE_ABORT = 0;
    localparam int VALVE_PRESS = 1;
    localparam int VALVE_VENT  = 2;
    localparam int VALVE_N2    = 3;
    localparam int VALVE_OX    = 4;

    typedef struct packed {
        logic [SENSOR_W-1:0] n2_target;
        logic [SENSOR_W-1:0] pause_trig;
        logic [SENSOR_W-1:0] pause_tgt;
        logic [SENSOR_W-1:0] pre_trig;
        logic [SENSOR_W-1:0] pre_tgt;
        logic [SENSOR_W-1:0] post_trig;
        logic [SENSOR_W-1:0] post_tgt;
        logic [SENSOR_W-1:0] ox_weight;
        logic [SENSOR_W-1:0] ox_vent_trig;
        logic [SENSOR_W-1:0] ox_vent_tgt;
        logic [SENSOR_W-1:0] ox_vent_temp;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SENSOR_W-1:0] ox_pressure;
        logic [SENSOR_W-1:0] n2_pressure;
        logic [SENSOR_W-1:0] ox_weight;
        logic [SENSOR_W-1:0] ox_temp;
    } t_sample;

    function automatic logic [VALVE_W-1:0] entry_valves(input t_leaf leaf);
        logic [VALVE_W-1:0] v;
        v = '0;
        unique case (leaf)
            LEAF_ABORT: begin
                v[VALVE_ABORT] = 1'b1;
                v[VALVE_PRESS] = 1'b1;
            end
            LEAF_PAUSE_VENT, LEAF_PRE_VENT, LEAF_POST_VENT: v[VALVE_VENT] = 1'b1;
            LEAF_N2_FILL, LEAF_POST_FILL: v[VALVE_N2] = 1'b1;
            LEAF_PRE_FILL: v[VALVE_PRESS] = 1'b1;
            LEAF_OX_FILL: v[VALVE_OX] = 1'b1;
            LEAF_OX_VENT: begin
                v[VALVE_OX]   = 1'b1;
                v[VALVE_VENT] = 1'b1;
            end
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pfs_cfg.sv
`default_nettype none

module pfs_cfg
    import pfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_N2_TARGET:    r_cfg.n2_target <= i_cfg_data[SENSOR_W-1:0];
                CFG_PAUSE_LIMITS: begin
                    r_cfg.pause_trig <= i_cfg_data[2*SENSOR_W-1:SENSOR_W];
                    r_cfg.pause_tgt  <= i_cfg_data[SENSOR_W-1:0];
                end
                CFG_PRE_LIMITS: begin
                    r_cfg.pre_trig <= i_cfg_data[2*SENSOR_W-1:SENSOR_W];
                    r_cfg.pre_tgt  <= i_cfg_data[SENSOR_W-1:0];
                end
                CFG_POST_LIMITS: begin
                    r_cfg.post_trig <= i_cfg_data[2*SENSOR_W-1:SENSOR_W];
                    r_cfg.post_tgt  <= i_cfg_data[SENSOR_W-1:0];
                end
                CFG_OX_WEIGHT:    r_cfg.ox_weight    <= i_cfg_data[SENSOR_W-1:0];
                CFG_OX_VENT_TRIG: r_cfg.ox_vent_trig <= i_cfg_data[SENSOR_W-1:0];
                CFG_OX_VENT_TGT:  r_cfg.ox_vent_tgt  <= i_cfg_data[SENSOR_W-1:0];
                CFG_OX_VENT_TEMP: r_cfg.ox_vent_temp <= i_cfg_data[SENSOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/pfs_next.sv
`default_nettype none

module pfs_next
    import pfs_pkg::*;
(
    input  wire t_leaf   i_leaf,
    input  wire t_sample i_sample,
    input  wire t_cfg    i_cfg,
    output t_leaf        o_leaf
);

    logic  global_cmd;
    logic  thr_hit;
    t_leaf thr_leaf;
    logic  moved;
    t_leaf n_leaf;
    logic  temp_hot;
    logic [SENSOR_W-1:0] p;
    logic [SENSOR_W-1:0] w;
    logic [SENSOR_W-1:0] n2p;
    logic [FUNC_W-1:0]   func;

    assign func = i_sample.func;
    assign p    = i_sample.ox_pressure;
    assign w    = i_sample.ox_weight;
    assign n2p  = i_sample.n2_pressure;

    assign global_cmd = (func == FUNC_STOP) || (func == FUNC_ABORT) || (func == FUNC_PAUSE);
    assign temp_hot   = $signed(i_sample.ox_temp) > $signed(i_cfg.ox_vent_temp);

    // threshold checks of the current sub-state
    always_comb begin
        thr_hit  = 1'b0;
        thr_leaf = LEAF_IDLE;
        unique case (i_leaf)
            LEAF_PAUSE_IDLE: begin
                thr_hit  = p > i_cfg.pause_trig;
                thr_leaf = LEAF_PAUSE_VENT;
            end
            LEAF_PAUSE_VENT: begin
                thr_hit  = p <= i_cfg.pause_tgt;
                thr_leaf = LEAF_PAUSE_IDLE;
            end
            LEAF_N2_IDLE: begin
                thr_hit  = n2p <= i_cfg.n2_target;
                thr_leaf = LEAF_N2_FILL;
            end
            LEAF_N2_FILL: begin
                thr_hit  = n2p >= i_cfg.n2_target;
                thr_leaf = LEAF_N2_IDLE;
            end
            LEAF_PRE_IDLE: begin
                thr_hit  = (p > i_cfg.pre_trig) || (p < i_cfg.pre_tgt);
                thr_leaf = (p > i_cfg.pre_trig) ? LEAF_PRE_VENT : LEAF_PRE_FILL;
            end
            LEAF_PRE_VENT: begin
                thr_hit  = p <= i_cfg.pre_tgt;
                thr_leaf = LEAF_PRE_IDLE;
            end
            LEAF_PRE_FILL: begin
                thr_hit  = p >= i_cfg.pre_tgt;
                thr_leaf = LEAF_PRE_IDLE;
            end
            LEAF_OX_IDLE: begin
                thr_hit  = w < i_cfg.ox_weight;
                thr_leaf = LEAF_OX_FILL;
            end
            LEAF_OX_FILL: begin
                // venting wins over reaching the target weight
                thr_hit  = ((p >= i_cfg.ox_vent_trig) && temp_hot) || (w >= i_cfg.ox_weight);
                thr_leaf = ((p >= i_cfg.ox_vent_trig) && temp_hot) ? LEAF_OX_VENT
                                                                   : LEAF_OX_IDLE;
            end
            LEAF_OX_VENT: begin
                thr_hit  = (p <= i_cfg.ox_vent_tgt) || !temp_hot;
                thr_leaf = LEAF_OX_FILL;
            end
            LEAF_POST_IDLE: begin
                thr_hit  = (p > i_cfg.post_trig) || (p < i_cfg.post_tgt);
                thr_leaf = (p > i_cfg.post_trig) ? LEAF_POST_VENT : LEAF_POST_FILL;
            end
            LEAF_POST_VENT: begin
                thr_hit  = p <= i_cfg.post_tgt;
                thr_leaf = LEAF_POST_IDLE;
            end
            LEAF_POST_FILL: begin
                thr_hit  = p >= i_cfg.post_tgt;
                thr_leaf = LEAF_POST_IDLE;
            end
            default: begin
                thr_hit  = 1'b0;
                thr_leaf = LEAF_IDLE;
            end
        endcase
    end

    always_comb begin
        moved  = 1'b0;
        n_leaf = i_leaf;
        priority if (i_leaf == LEAF_IDLE) begin
            moved = 1'b1;
            priority case (func)
                FUNC_FILL_N2:    n_leaf = LEAF_N2_IDLE;
                FUNC_PRE_PRESS:  n_leaf = LEAF_PRE_IDLE;
                FUNC_FILL_OX:    n_leaf = LEAF_OX_IDLE;
                FUNC_POST_PRESS: n_leaf = LEAF_POST_IDLE;
                default:         moved  = 1'b0;
            endcase
        end else if (i_leaf == LEAF_ABORT) begin
            if (func == FUNC_READY) begin
                moved  = 1'b1;
                n_leaf = LEAF_IDLE;
            end
        end else if (!global_cmd) begin
            if (thr_hit) begin
                moved  = 1'b1;
                n_leaf = thr_leaf;
            end else if ((i_leaf == LEAF_PAUSE_IDLE || i_leaf == LEAF_PAUSE_VENT)
                         && func == FUNC_RESUME) begin
                moved  = 1'b1;
                n_leaf = LEAF_IDLE;
            end
        end else begin
            moved = 1'b0;
        end

        if (!moved && global_cmd) begin
            priority case (func)
                FUNC_STOP:  n_leaf = LEAF_IDLE;
                FUNC_ABORT: n_leaf = LEAF_ABORT;
                default:    n_leaf = LEAF_PAUSE_IDLE;
            endcase
        end
    end

    assign o_leaf = n_leaf;

endmodule

`default_nettype wire

FILE: rtl/propellant_fill_sequencer.sv
// path: a request passes the input register, then the result register, to the outputs;
// it waits while the output stalls; the leaf state loop closes through one register
// throughput: one request per cycle unless the output side stalls
// reset: synchronous active-low; leaf idles, all valves closed, valid and cfg cleared
`default_nettype none

module propellant_fill_sequencer
    import pfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [SENSOR_W-1:0]   i_oxidizer_pressure,
    input  wire logic [SENSOR_W-1:0]   i_nitrogen_pressure,
    input  wire logic [SENSOR_W-1:0]   i_oxidizer_weight,
    input  wire logic [SENSOR_W-1:0]   i_oxidizer_temperature,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [LEAF_W-1:0]          o_leaf_state,
    output logic                       o_abort_valve,
    output logic                       o_pressurizing_valve,
    output logic                       o_vent_valve,
    output logic                       o_nitrogen_fill_valve,
    output logic                       o_oxidizer_fill_valve
);

    t_cfg    cfg;
    t_sample r_sample;
    logic    r_in_valid;
    logic    r_out_valid;
    t_leaf   r_leaf;
    t_leaf   n_leaf;
    logic [VALVE_W-1:0] r_valves;
    logic    advance;
    logic    take;

    pfs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pfs_next u_next (
        .i_leaf   (r_leaf),
        .i_sample (r_sample),
        .i_cfg    (cfg),
        .o_leaf   (n_leaf)
    );

    // the result register doubles as the leaf state
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take || advance) begin
            r_in_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample.func        <= i_func;
            r_sample.ox_pressure <= i_oxidizer_pressure;
            r_sample.n2_pressure <= i_nitrogen_pressure;
            r_sample.ox_weight   <= i_oxidizer_weight;
            r_sample.ox_temp     <= i_oxidizer_temperature;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_leaf      <= LEAF_IDLE;
            r_valves    <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_leaf      <= n_leaf;
                r_valves    <= entry_valves(n_leaf);
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid               = r_out_valid;
    assign o_leaf_state          = r_leaf;
    assign o_abort_valve         = r_valves[VALVE_ABORT];
    assign o_pressurizing_valve  = r_valves[VALVE_PRESS];
    assign o_vent_valve          = r_valves[VALVE_VENT];
    assign o_nitrogen_fill_valve = r_valves[VALVE_N2];
    assign o_oxidizer_fill_valve = r_valves[VALVE_OX];

endmodule

`default_nettype wire

FILE: verif/tb.sv
module tb
    import pfs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [FUNC_W-1:0]    FUNC_UNDEF_LO = FUNC_RESUME + 4'd1;
    localparam logic [FUNC_W-1:0]    FUNC_UNDEF_HI = 4'hF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_OX_VENT_TEMP + 4'd1;

    typedef struct {
        logic [FUNC_W-1:0]          func;
        logic [SENSOR_W-1:0]        ox_pressure;
        logic [SENSOR_W-1:0]        n2_pressure;
        logic [SENSOR_W-1:0]        ox_weight;
        logic signed [SENSOR_W-1:0] ox_temp;
    } t_req;

    typedef struct {
        t_leaf              leaf;
        logic [VALVE_W-1:0] valves;
    } t_tick_out;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [FUNC_W-1:0]     i_func = FUNC_NONE;
    logic [SENSOR_W-1:0]   i_oxidizer_pressure = '0;
    logic [SENSOR_W-1:0]   i_nitrogen_pressure = '0;
    logic [SENSOR_W-1:0]   i_oxidizer_weight = '0;
    logic [SENSOR_W-1:0]   i_oxidizer_temperature = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [LEAF_W-1:0]     o_leaf_state;
    logic                  o_abort_valve;
    logic                  o_pressurizing_valve;
    logic                  o_vent_valve;
    logic                  o_nitrogen_fill_valve;
    logic                  o_oxidizer_fill_valve;

    propellant_fill_sequencer dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_func                (i_func),
        .i_oxidizer_pressure   (i_oxidizer_pressure),
        .i_nitrogen_pressure   (i_nitrogen_pressure),
        .i_oxidizer_weight     (i_oxidizer_weight),
        .i_oxidizer_temperature(i_oxidizer_temperature),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_leaf_state          (o_leaf_state),
        .o_abort_valve         (o_abort_valve),
        .o_pressurizing_valve  (o_pressurizing_valve),
        .o_vent_valve          (o_vent_valve),
        .o_nitrogen_fill_valve (o_nitrogen_fill_valve),
        .o_oxidizer_fill_valve (o_oxidizer_fill_valve)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // sequencer state and limits as the block should hold them
    t_leaf                      fsm_leaf = LEAF_IDLE;
    logic [VALVE_W-1:0]         fsm_valves = '0;
    logic [SENSOR_W-1:0]        cfg_n2_target = '0;
    logic [CFG_DATA_W-1:0]      cfg_pause = '0;
    logic [CFG_DATA_W-1:0]      cfg_pre = '0;
    logic [CFG_DATA_W-1:0]      cfg_post = '0;
    logic [SENSOR_W-1:0]        cfg_ox_weight = '0;
    logic [SENSOR_W-1:0]        cfg_ox_vent_trig = '0;
    logic [SENSOR_W-1:0]        cfg_ox_vent_tgt = '0;
    logic signed [SENSOR_W-1:0] cfg_ox_vent_temp = '0;

    t_tick_out pending_ticks[$];
    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        stall_hold = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic logic [VALVE_W-1:0] valves_on_entry(input t_leaf leaf);
        logic [VALVE_W-1:0] v;
        v[VALVE_ABORT] = (leaf == LEAF_ABORT);
        v[VALVE_PRESS] = (leaf == LEAF_ABORT) || (leaf == LEAF_PRE_FILL);
        v[VALVE_VENT]  = (leaf == LEAF_PAUSE_VENT) || (leaf == LEAF_PRE_VENT) ||
                         (leaf == LEAF_POST_VENT) || (leaf == LEAF_OX_VENT);
        v[VALVE_N2]    = (leaf == LEAF_N2_FILL) || (leaf == LEAF_POST_FILL);
        v[VALVE_OX]    = (leaf == LEAF_OX_FILL) || (leaf == LEAF_OX_VENT);
        return v;
    endfunction

    // sub-state threshold checks; returns the current leaf when nothing fires
    function automatic t_leaf next_by_threshold(input t_req r);
        t_leaf nxt;
        nxt = fsm_leaf;
        case (fsm_leaf)
            LEAF_PAUSE_IDLE: if (r.ox_pressure > cfg_pause[31:16]) nxt = LEAF_PAUSE_VENT;
            LEAF_PAUSE_VENT: if (r.ox_pressure <= cfg_pause[15:0]) nxt = LEAF_PAUSE_IDLE;
            LEAF_N2_IDLE:    if (r.n2_pressure <= cfg_n2_target) nxt = LEAF_N2_FILL;
            LEAF_N2_FILL:    if (r.n2_pressure >= cfg_n2_target) nxt = LEAF_N2_IDLE;
            LEAF_PRE_IDLE: begin
                if (r.ox_pressure > cfg_pre[31:16]) nxt = LEAF_PRE_VENT;
                else if (r.ox_pressure < cfg_pre[15:0]) nxt = LEAF_PRE_FILL;
            end
            LEAF_PRE_VENT:   if (r.ox_pressure <= cfg_pre[15:0]) nxt = LEAF_PRE_IDLE;
            LEAF_PRE_FILL:   if (r.ox_pressure >= cfg_pre[15:0]) nxt = LEAF_PRE_IDLE;
            LEAF_OX_IDLE:    if (r.ox_weight < cfg_ox_weight) nxt = LEAF_OX_FILL;
            LEAF_OX_FILL: begin
                if (r.ox_pressure >= cfg_ox_vent_trig && r.ox_temp > cfg_ox_vent_temp)
                    nxt = LEAF_OX_VENT;
                else if (r.ox_weight >= cfg_ox_weight) nxt = LEAF_OX_IDLE;
            end
            LEAF_OX_VENT: begin
                if (r.ox_pressure <= cfg_ox_vent_tgt || r.ox_temp <= cfg_ox_vent_temp)
                    nxt = LEAF_OX_FILL;
            end
            LEAF_POST_IDLE: begin
                if (r.ox_pressure > cfg_post[31:16]) nxt = LEAF_POST_VENT;
                else if (r.ox_pressure < cfg_post[15:0]) nxt = LEAF_POST_FILL;
            end
            LEAF_POST_VENT:  if (r.ox_pressure <= cfg_post[15:0]) nxt = LEAF_POST_IDLE;
            LEAF_POST_FILL:  if (r.ox_pressure >= cfg_post[15:0]) nxt = LEAF_POST_IDLE;
            default: ;
        endcase
        return nxt;
    endfunction

    task automatic advance_sequencer(input t_req r);
        logic      is_global;
        logic      moved;
        t_leaf     nxt;
        t_tick_out res;
        is_global = (r.func == FUNC_STOP) || (r.func == FUNC_ABORT) || (r.func == FUNC_PAUSE);
        moved = 1'b0;
        nxt = fsm_leaf;
        if (fsm_leaf == LEAF_IDLE) begin
            moved = 1'b1;
            case (r.func)
                FUNC_FILL_N2:    nxt = LEAF_N2_IDLE;
                FUNC_PRE_PRESS:  nxt = LEAF_PRE_IDLE;
                FUNC_FILL_OX:    nxt = LEAF_OX_IDLE;
                FUNC_POST_PRESS: nxt = LEAF_POST_IDLE;
                default:         moved = 1'b0;
            endcase
        end else if (fsm_leaf == LEAF_ABORT) begin
            if (r.func == FUNC_READY) begin
                nxt = LEAF_IDLE;
                moved = 1'b1;
            end
        end else if (!is_global) begin
            nxt = next_by_threshold(r);
            moved = (nxt != fsm_leaf);
            if (!moved && r.func == FUNC_RESUME &&
                (fsm_leaf == LEAF_PAUSE_IDLE || fsm_leaf == LEAF_PAUSE_VENT)) begin
                nxt = LEAF_IDLE;
                moved = 1'b1;
            end
        end
        // global commands re-enter even the group they already sit in
        if (!moved && is_global) begin
            moved = 1'b1;
            if (r.func == FUNC_STOP) nxt = LEAF_IDLE;
            else if (r.func == FUNC_ABORT) nxt = LEAF_ABORT;
            else nxt = LEAF_PAUSE_IDLE;
        end
        if (moved) begin
            fsm_leaf = nxt;
            fsm_valves = valves_on_entry(nxt);
        end
        res.leaf = fsm_leaf;
        res.valves = fsm_valves;
        pending_ticks.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_tick_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_ticks.size() == 0) begin
                report_mismatch("result with nothing pending", o_leaf_state, -1);
            end else begin
                want = pending_ticks.pop_front();
                if (o_leaf_state !== want.leaf)
                    report_mismatch("leaf_state", o_leaf_state, want.leaf);
                if (o_abort_valve !== want.valves[VALVE_ABORT])
                    report_mismatch("abort_valve", o_abort_valve, want.valves[VALVE_ABORT]);
                if (o_pressurizing_valve !== want.valves[VALVE_PRESS])
                    report_mismatch("pressurizing_valve", o_pressurizing_valve,
                                    want.valves[VALVE_PRESS]);
                if (o_vent_valve !== want.valves[VALVE_VENT])
                    report_mismatch("vent_valve", o_vent_valve, want.valves[VALVE_VENT]);
                if (o_nitrogen_fill_valve !== want.valves[VALVE_N2])
                    report_mismatch("nitrogen_fill_valve", o_nitrogen_fill_valve,
                                    want.valves[VALVE_N2]);
                if (o_oxidizer_fill_valve !== want.valves[VALVE_OX])
                    report_mismatch("oxidizer_fill_valve", o_oxidizer_fill_valve,
                                    want.valves[VALVE_OX]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_stall <= 1'b1;
            stall_hold--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_req(input t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid                <= 1'b1;
        i_func                 <= r.func;
        i_oxidizer_pressure    <= r.ox_pressure;
        i_nitrogen_pressure    <= r.n2_pressure;
        i_oxidizer_weight      <= r.ox_weight;
        i_oxidizer_temperature <= r.ox_temp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_sequencer(r);
    endtask

    task automatic send_fields(input logic [FUNC_W-1:0] f, input logic [15:0] p,
                               input logic [15:0] n2, input logic [15:0] w,
                               input logic [15:0] t);
        t_req r;
        r.func = f;
        r.ox_pressure = p;
        r.n2_pressure = n2;
        r.ox_weight = w;
        r.ox_temp = t;
        send_req(r);
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_N2_TARGET:    cfg_n2_target = data[15:0];
            CFG_PAUSE_LIMITS: cfg_pause = data;
            CFG_PRE_LIMITS:   cfg_pre = data;
            CFG_POST_LIMITS:  cfg_post = data;
            CFG_OX_WEIGHT:    cfg_ox_weight = data[15:0];
            CFG_OX_VENT_TRIG: cfg_ox_vent_trig = data[15:0];
            CFG_OX_VENT_TGT:  cfg_ox_vent_tgt = data[15:0];
            CFG_OX_VENT_TEMP: cfg_ox_vent_temp = data[15:0];
            default: ;
        endcase
    endtask

    task automatic release_cfg_port();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] limit_value();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65000, 200));
        endcase
    endfunction

    // upper halves of the 16-bit registers carry junk that must be dropped
    task automatic program_random_limits();
        write_reg(CFG_N2_TARGET, {16'($urandom), limit_value()});
        write_reg(CFG_PAUSE_LIMITS, {limit_value(), limit_value()});
        write_reg(CFG_PRE_LIMITS, {limit_value(), limit_value()});
        write_reg(CFG_POST_LIMITS, {limit_value(), limit_value()});
        write_reg(CFG_OX_WEIGHT, {16'($urandom), limit_value()});
        write_reg(CFG_OX_VENT_TRIG, {16'($urandom), limit_value()});
        write_reg(CFG_OX_VENT_TGT, {16'($urandom), limit_value()});
        write_reg(CFG_OX_VENT_TEMP, {16'($urandom), limit_value()});
        write_reg(CFG_UNUSED_LO + 4'($urandom_range(7)), $urandom);
        release_cfg_port();
    endtask

    task automatic program_all(input logic [CFG_DATA_W-1:0] data);
        write_reg(CFG_N2_TARGET, data);
        write_reg(CFG_PAUSE_LIMITS, data);
        write_reg(CFG_PRE_LIMITS, data);
        write_reg(CFG_POST_LIMITS, data);
        write_reg(CFG_OX_WEIGHT, data);
        write_reg(CFG_OX_VENT_TRIG, data);
        write_reg(CFG_OX_VENT_TGT, data);
        write_reg(CFG_OX_VENT_TEMP, data);
        release_cfg_port();
    endtask

    function automatic logic [15:0] around(input logic [15:0] th);
        case ($urandom_range(7))
            0, 1: return 16'($urandom);
            2: return th;
            3: return th + 16'd1;
            4: return th - 16'd1;
            5: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return th + 16'($urandom_range(64)) - 16'd32;
        endcase
    endfunction

    function automatic logic [15:0] pressure_threshold();
        case (fsm_leaf)
            LEAF_PAUSE_IDLE: return cfg_pause[31:16];
            LEAF_PAUSE_VENT: return cfg_pause[15:0];
            LEAF_PRE_IDLE:   return $urandom_range(1) ? cfg_pre[31:16] : cfg_pre[15:0];
            LEAF_PRE_VENT, LEAF_PRE_FILL: return cfg_pre[15:0];
            LEAF_OX_FILL:    return cfg_ox_vent_trig;
            LEAF_OX_VENT:    return cfg_ox_vent_tgt;
            LEAF_POST_IDLE:  return $urandom_range(1) ? cfg_post[31:16] : cfg_post[15:0];
            LEAF_POST_VENT, LEAF_POST_FILL: return cfg_post[15:0];
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly sensible command flow for the current leaf, with some noise
    function automatic logic [FUNC_W-1:0] pick_cmd();
        int roll;
        roll = $urandom_range(99);
        if (fsm_leaf == LEAF_IDLE) begin
            if (roll < 80) return FUNC_FILL_N2 + 4'($urandom_range(3));
        end else if (fsm_leaf == LEAF_ABORT) begin
            if (roll < 40) return FUNC_READY;
        end else begin
            if (roll < 72) return FUNC_NONE;
            if (roll < 78) return FUNC_RESUME;
            if (roll < 82) return FUNC_READY;
            if (roll < 86) return FUNC_STOP;
            if (roll < 88) return FUNC_ABORT;
            if (roll < 91) return FUNC_PAUSE;
        end
        return 4'($urandom_range(15));
    endfunction

    task automatic run_random(input int count);
        t_req r;
        repeat (count) begin
            r.func = pick_cmd();
            r.ox_pressure = around(pressure_threshold());
            r.n2_pressure = around(cfg_n2_target);
            r.ox_weight = around(cfg_ox_weight);
            r.ox_temp = around(cfg_ox_vent_temp);
            send_req(r);
        end
        go_quiet();
        wait_drained();
    endtask

    task automatic test_after_reset();
        send_idle_pct = 0;
        stall_pct = 0;
        run_random(20);
    endtask

    task automatic test_directed();
        write_reg(CFG_N2_TARGET, 32'd1000);
        write_reg(CFG_PAUSE_LIMITS, {16'd500, 16'd200});
        write_reg(CFG_PRE_LIMITS, {16'd800, 16'd600});
        write_reg(CFG_POST_LIMITS, {16'd900, 16'd700});
        write_reg(CFG_OX_WEIGHT, 32'd3000);
        write_reg(CFG_OX_VENT_TRIG, 32'd400);
        write_reg(CFG_OX_VENT_TGT, 32'd300);
        write_reg(CFG_OX_VENT_TEMP, 32'h0000_FFFB);    // -5
        release_cfg_port();
        send_fields(FUNC_NONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // undefined codes behave as no command, fields at their extremes
        send_fields(FUNC_UNDEF_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
        send_fields(FUNC_UNDEF_HI, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        send_fields(FUNC_READY, 0, 0, 0, 0);
        // nitrogen fill cycle
        send_fields(FUNC_FILL_N2, 0, 0, 0, 0);
        send_fields(FUNC_NONE, 0, 16'd1000, 0, 0);
        send_fields(FUNC_NONE, 0, 16'd999, 0, 0);
        send_fields(FUNC_NONE, 0, 16'd1000, 0, 0);
        // pause skips the threshold that would fire; ready ignored in pause
        send_fields(FUNC_PAUSE, 0, 0, 0, 0);
        send_fields(FUNC_READY, 0, 0, 0, 0);
        send_fields(FUNC_NONE, 16'd501, 0, 0, 0);
        send_fields(FUNC_RESUME, 16'd201, 0, 0, 0);
        // abort: resume ignored, abort again re-enters, ready leaves
        send_fields(FUNC_ABORT, 0, 0, 0, 0);
        send_fields(FUNC_RESUME, 0, 0, 0, 0);
        send_fields(FUNC_ABORT, 0, 0, 0, 0);
        send_fields(FUNC_READY, 0, 0, 0, 0);
        send_fields(FUNC_PRE_PRESS, 0, 0, 0, 0);
        send_fields(FUNC_NONE, 16'd801, 0, 0, 0);
        send_fields(FUNC_NONE, 16'd600, 0, 0, 0);
        send_fields(FUNC_NONE, 16'd599, 0, 0, 0);
        send_fields(FUNC_STOP, 16'd600, 0, 0, 0);
        send_fields(FUNC_FILL_OX, 0, 0, 16'd2999, 0);
        send_fields(FUNC_NONE, 0, 0, 16'd2999, 0);
        send_fields(FUNC_NONE, 16'd400, 0, 0, 16'hFFFC);
        send_fields(FUNC_NONE, 16'd301, 0, 0, 16'hFFFB);
        send_fields(FUNC_NONE, 0, 0, 16'd3000, 0);
        // pause twice: the group is re-entered at its first leaf
        send_fields(FUNC_PAUSE, 0, 0, 0, 0);
        send_fields(FUNC_PAUSE, 16'hFFFF, 0, 0, 0);
        send_fields(FUNC_STOP, 0, 0, 0, 0);
        send_fields(FUNC_POST_PRESS, 0, 0, 0, 0);
        send_fields(FUNC_NONE, 16'd901, 0, 0, 0);
        send_fields(FUNC_RESUME, 16'd700, 0, 0, 0);
        send_fields(FUNC_NONE, 0, 0, 0, 0);
        send_fields(FUNC_ABORT, 0, 0, 0, 0);
        send_fields(FUNC_READY, 0, 0, 0, 0);
        go_quiet();
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        send_idle_pct = 20;
        stall_pct = 20;
        program_all('0);
        run_random(60);
        program_all('1);
        run_random(60);
    endtask

    task automatic test_backpressure();
        program_random_limits();
        send_idle_pct = 0;
        stall_pct = 0;
        stall_hold = 300;
        run_random(60);
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 80 : 0;
            stall_pct     = (mode == 0) ? 80 : (mode == 1) ? 7 : 0;
            repeat (4) begin
                program_random_limits();
                run_random(145);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_directed();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
